// File: hw/rtl/gdate_pkg.sv
// Shared types, codes and calendar helpers for the Gregorian date block.
package gdate_pkg;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2,
		OP_CMP  = 2'd3
	} op_t;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 16;
	localparam int unsigned COUNT_W = 16;
	// Working accumulator: a stored day plus the largest day count.
	localparam int unsigned ACC_W   = 17;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	localparam logic [DAY_W-1:0]   LEAP_FEB_LEN = 5'd29;
	localparam logic [DAY_W-1:0]   LONG_LEN     = 5'd31;
	localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic add_step;
		logic add_done;
		logic sub_step;
		logic sub_last;
		logic sub_fill;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic add_more;
		logic sub_zero;
		logic sub_borrow;
	} stat_t;

	// Leap year test. Divisibility by 25 is found by folding the year with
	// 256 = 6 and 32 = 7 (mod 25) until the residue is below 128.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [10:0] s1;
		logic [8:0]  s2;
		logic [6:0]  s3;
		logic        div25;
		s1 = 11'(y[15:8]) * 11'd6 + 11'(y[7:0]);
		s2 = 9'(s1[10:5]) * 9'd7 + 9'(s1[4:0]);
		s3 = 7'(s2[8:5]) * 7'd7 + 7'(s2[4:0]);
		div25 = (s3 == 7'd0) || (s3 == 7'd25) || (s3 == 7'd50) ||
			(s3 == 7'd75) || (s3 == 7'd100);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	// Length of a month; months outside one to twelve count as 31 days.
	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
			input logic [YEAR_W-1:0] y);
		logic [MONTH_W-1:0] idx;
		idx = m - MONTH_JAN;
		if (m < MONTH_JAN || m > MONTH_DEC) begin
			return LONG_LEN;
		end else if (m == MONTH_FEB && is_leap(y)) begin
			return LEAP_FEB_LEN;
		end else begin
			return MONTH_LEN[idx];
		end
	endfunction

endpackage

// File: hw/rtl/gdate_dp.sv
// Date registers, month stepping, day accumulator, compare and result register.
module gdate_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gdate_pkg::cmd_t                     cmd,
	output gdate_pkg::stat_t                    stat,
	input  gdate_pkg::op_t                      op,
	input  logic [gdate_pkg::DAY_W-1:0]         in_day,
	input  logic [gdate_pkg::MONTH_W-1:0]       in_month,
	input  logic [gdate_pkg::YEAR_W-1:0]        in_year,
	input  logic [gdate_pkg::COUNT_W-1:0]       day_count,
	output logic [gdate_pkg::DAY_W-1:0]         cur_day,
	output logic [gdate_pkg::MONTH_W-1:0]       cur_month,
	output logic [gdate_pkg::YEAR_W-1:0]        cur_year,
	output logic                                is_before,
	output logic                                is_after,
	output logic                                is_equal
);

	logic [gdate_pkg::DAY_W-1:0]   day_q;
	logic [gdate_pkg::MONTH_W-1:0] month_q;
	logic [gdate_pkg::YEAR_W-1:0]  year_q;
	logic [gdate_pkg::ACC_W-1:0]   acc_q;
	logic                          before_q;
	logic                          after_q;
	logic                          equal_q;

	logic [gdate_pkg::DAY_W-1:0]   len;
	logic [gdate_pkg::MONTH_W-1:0] month_inc;
	logic [gdate_pkg::YEAR_W-1:0]  year_inc;
	logic [gdate_pkg::MONTH_W-1:0] month_dec;
	logic [gdate_pkg::YEAR_W-1:0]  year_dec;
	logic                          cmp_before;
	logic                          cmp_equal;
	logic                          is_cmp;

	assign len = gdate_pkg::days_in(month_q, year_q);

	always_comb begin
		if (month_q >= gdate_pkg::MONTH_DEC) begin
			month_inc = gdate_pkg::MONTH_JAN;
			year_inc  = year_q + 16'd1;
		end else begin
			month_inc = month_q + 4'd1;
			year_inc  = year_q;
		end
		if (month_q == gdate_pkg::MONTH_JAN) begin
			month_dec = gdate_pkg::MONTH_DEC;
			year_dec  = year_q - 16'd1;
		end else begin
			month_dec = month_q - 4'd1;
			year_dec  = year_q;
		end
	end

	// Ordered by year, then month, then day.
	assign cmp_equal  = (year_q == in_year) && (month_q == in_month) && (day_q == in_day);
	assign cmp_before = (year_q < in_year) ||
		((year_q == in_year) && ((month_q < in_month) ||
		((month_q == in_month) && (day_q < in_day))));
	assign is_cmp     = op == gdate_pkg::OP_CMP;

	assign stat.add_more   = acc_q > gdate_pkg::ACC_W'(len);
	assign stat.sub_zero   = acc_q == '0;
	assign stat.sub_borrow = acc_q >= gdate_pkg::ACC_W'(day_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= 5'd1;
			month_q <= gdate_pkg::MONTH_JAN;
			year_q  <= '0;
		end else begin
			if (cmd.start && op == gdate_pkg::OP_LOAD) begin
				day_q   <= in_day;
				month_q <= in_month;
				year_q  <= in_year;
			end
			if (cmd.add_step) begin
				month_q <= month_inc;
				year_q  <= year_inc;
			end
			if (cmd.add_done) begin
				day_q <= acc_q[gdate_pkg::DAY_W-1:0];
			end
			if (cmd.sub_step) begin
				month_q <= month_dec;
				year_q  <= year_dec;
			end
			if (cmd.sub_last) begin
				day_q <= day_q - acc_q[gdate_pkg::DAY_W-1:0];
			end
			if (cmd.sub_fill) begin
				day_q <= len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			// The flags are only meaningful for a compare and read as zero otherwise.
			before_q <= is_cmp && cmp_before;
			after_q  <= is_cmp && !cmp_before && !cmp_equal;
			equal_q  <= is_cmp && cmp_equal;
			case (op)
				gdate_pkg::OP_ADD: acc_q <= gdate_pkg::ACC_W'(day_q) +
					gdate_pkg::ACC_W'(day_count);
				gdate_pkg::OP_SUB: acc_q <= gdate_pkg::ACC_W'(day_count);
				default: acc_q <= acc_q;
			endcase
		end
		if (cmd.add_step) begin
			acc_q <= acc_q - gdate_pkg::ACC_W'(len);
		end
		if (cmd.sub_step) begin
			acc_q <= acc_q - gdate_pkg::ACC_W'(day_q);
		end
		if (cmd.sub_last) begin
			acc_q <= '0;
		end
		if (cmd.out_load) begin
			cur_day   <= day_q;
			cur_month <= month_q;
			cur_year  <= year_q;
			is_before <= before_q;
			is_after  <= after_q;
			is_equal  <= equal_q;
		end
	end

`ifndef SYNTHESIS
	a_add_step_needed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_step |-> acc_q > gdate_pkg::ACC_W'(len))
		else $error("add stepped a month with the day inside the month");
	a_sub_step_needed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sub_step |-> (acc_q != '0) && (acc_q >= gdate_pkg::ACC_W'(day_q)))
		else $error("subtract borrowed a month without need");
	a_add_month_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_step |=> (month_q != '0) && (month_q <= gdate_pkg::MONTH_DEC))
		else $error("month out of range after an add step");
`endif

endmodule

// File: hw/rtl/gdate_ctrl.sv
// Sequencer for load, add, subtract and compare, plus the result valid flag.
module gdate_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  gdate_pkg::op_t   op,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  gdate_pkg::stat_t stat,
	output gdate_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SUB,
		S_FILL,
		S_PUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					unique case (op)
						gdate_pkg::OP_ADD: state_d = S_ADD;
						gdate_pkg::OP_SUB: state_d = S_SUB;
						default:           state_d = S_PUT;
					endcase
				end
			end
			S_ADD: begin
				if (stat.add_more) begin
					cmd.add_step = 1'b1;
				end else begin
					cmd.add_done = 1'b1;
					state_d      = S_PUT;
				end
			end
			S_SUB: begin
				if (stat.sub_zero) begin
					state_d = S_PUT;
				end else if (stat.sub_borrow) begin
					cmd.sub_step = 1'b1;
					state_d      = S_FILL;
				end else begin
					cmd.sub_last = 1'b1;
					state_d      = S_PUT;
				end
			end
			S_FILL: begin
				cmd.sub_fill = 1'b1;
				state_d      = S_SUB;
			end
			S_PUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_valid_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PUT))
		else $error("result valid raised outside the result hand-off");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while a transaction waits");
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("result valid dropped while the transaction was stalled");
`endif

endmodule

// File: hw/rtl/gregorian_date_add_sub_compare.sv
// Gregorian date register with add, subtract and compare.
//
//   Channel  Direction  Handshake            Payload
//   in       to block   in_valid / in_stall  op, in_day, in_month, in_year, day_count
//   out      from block out_valid / out_stall cur_day, cur_month, cur_year,
//                                            is_before, is_after, is_equal
//
// One transaction is worked on at a time. Load and compare pass from acceptance
// through the result step into the result register. Add steps once for each
// month boundary crossed, and subtract steps back and then refills the day for
// each month stepped back: the month stepping loop advances one month per pass
// through the shared day accumulator and days-in-month logic.
// After reset the stored date is day 1, month 1, year 0 and no result is valid.
// The result register lets a new transaction be accepted while the previous
// result is still stalled; the new one then waits in its final step.
//
// The controller sequences each operation and the datapath holds the date, the
// day accumulator (day sum for add, remaining count for subtract), the compare
// flags and the result register. Leap years follow the Gregorian rule and the
// year wraps modulo 65536 in both directions.
module gregorian_date_add_sub_compare (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic [gdate_pkg::DAY_W-1:0]         in_day,
	input  logic [gdate_pkg::MONTH_W-1:0]       in_month,
	input  logic [gdate_pkg::YEAR_W-1:0]        in_year,
	input  logic [gdate_pkg::COUNT_W-1:0]       day_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [gdate_pkg::DAY_W-1:0]         cur_day,
	output logic [gdate_pkg::MONTH_W-1:0]       cur_month,
	output logic [gdate_pkg::YEAR_W-1:0]        cur_year,
	output logic                                is_before,
	output logic                                is_after,
	output logic                                is_equal
);

	gdate_pkg::cmd_t  cmd;
	gdate_pkg::stat_t stat;
	gdate_pkg::op_t   op_code;

	// The operation code is used by both halves; all four codes are meaningful.
	assign op_code = gdate_pkg::op_t'(op);

	gdate_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op_code),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	gdate_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.op        (op_code),
		.in_day    (in_day),
		.in_month  (in_month),
		.in_year   (in_year),
		.day_count (day_count),
		.cur_day   (cur_day),
		.cur_month (cur_month),
		.cur_year  (cur_year),
		.is_before (is_before),
		.is_after  (is_after),
		.is_equal  (is_equal)
	);

endmodule

// File: tb/sv/gregorian_date_add_sub_compare_tb.sv
module gregorian_date_add_sub_compare_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles in a row with no transaction on either channel before the run is
	// declared hung. The slowest legal transaction is a subtract of 65535 days:
	// about 2150 months stepped back, each with a borrow and a refill step, plus a long stall.
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned RANDOM_ITEMS   = 1200;
	localparam int unsigned TAIL_CYCLES    = 20;

	// One input transaction as it crosses the input channel.
	typedef struct {
		gdate_pkg::op_t op;
		logic [4:0]     day;
		logic [3:0]     month;
		logic [15:0]    year;
		logic [15:0]    count;
	} date_txn_t;

	// One result transaction as it crosses the output channel.
	typedef struct {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic        earlier;
		logic        later;
		logic        same;
	} date_res_t;

	// Receiver stall behaviors, each held for a random stretch of cycles.
	typedef enum int unsigned {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_HOLD
	} rx_mode_t;

	// How a compare transaction relates to the date the block holds.
	typedef enum int unsigned {
		CMP_SAME,
		CMP_YEAR_OFF,
		CMP_MONTH_OFF,
		CMP_DAY_OFF,
		CMP_RANDOM
	} cmp_mode_t;

	// The scoreboard keeps its own copy of the stored date, advances it for
	// every accepted input transaction and queues the result that must follow.
	class date_scoreboard;
		logic [16:0]  day;
		logic [3:0]   month;
		logic [15:0]  year;
		date_res_t    pending_dates[$];
		int unsigned  fails;
		int unsigned  op_seen[4];
		int unsigned  flag_seen[3];
		int unsigned  year_wraps;
		int unsigned  max_count;

		function new();
			day = 17'd1;
			month = 4'd1;
			year = 16'd0;
			fails = 0;
			year_wraps = 0;
			max_count = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
			foreach (flag_seen[i]) flag_seen[i] = 0;
		endfunction

		function bit leap_year(logic [15:0] y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		function int unsigned month_days(logic [3:0] m, logic [15:0] y);
			case (m)
				4'd2: begin
					return leap_year(y) ? 29 : 28;
				end
				4'd4, 4'd6, 4'd9, 4'd11: begin
					return 30;
				end
				default: begin
					return 31;
				end
			endcase
		endfunction

		// Adds whole months until the running day fits the current month.
		function void step_forward(int unsigned n);
			int unsigned acc;
			int unsigned len;
			int unsigned m;
			acc = day + n;
			m = month;
			len = month_days(4'(m), year);
			while (acc > len) begin
				acc -= len;
				m++;
				if (m > 12) begin
					m = 1;
					year++;
					if (year == 16'd0) year_wraps++;
				end
				len = month_days(4'(m), year);
			end
			month = 4'(m);
			day = acc[16:0];
		endfunction

		// Takes away the days of the current month, then moves to the end of
		// the month before, until what is left fits inside one month.
		function void step_back(int unsigned n);
			while (n > 0) begin
				if (n >= day) begin
					n -= day;
					if (month == 4'd1) begin
						month = 4'd12;
						year--;
						if (year == 16'hFFFF) year_wraps++;
					end else begin
						month = month - 4'd1;
					end
					day = 17'(month_days(month, year));
				end else begin
					day -= n;
					n = 0;
				end
			end
		endfunction

		function void accept_txn(date_txn_t t);
			date_res_t r;
			r.earlier = 1'b0;
			r.later = 1'b0;
			r.same = 1'b0;
			op_seen[t.op]++;
			case (t.op)
				gdate_pkg::OP_LOAD: begin
					day = 17'(t.day);
					month = t.month;
					year = t.year;
				end
				gdate_pkg::OP_ADD: begin
					step_forward(t.count);
					if (t.count > max_count) max_count = t.count;
				end
				gdate_pkg::OP_SUB: begin
					step_back(t.count);
					if (t.count > max_count) max_count = t.count;
				end
				default: begin
					if (year != t.year) begin
						r.earlier = year < t.year;
						r.later = year > t.year;
					end else if (month != t.month) begin
						r.earlier = month < t.month;
						r.later = month > t.month;
					end else begin
						r.earlier = day < 17'(t.day);
						r.later = day > 17'(t.day);
					end
					r.same = (year == t.year) && (month == t.month) &&
						(day == 17'(t.day));
					if (r.earlier) flag_seen[0]++;
					if (r.later) flag_seen[1]++;
					if (r.same) flag_seen[2]++;
				end
			endcase
			r.day = day[4:0];
			r.month = month;
			r.year = year;
			pending_dates.push_back(r);
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(date_res_t got);
			date_res_t want;
			if (pending_dates.size() == 0) begin
				$error("result transaction arrived with no input transaction outstanding");
				fails++;
				return;
			end
			want = pending_dates.pop_front();
			check_field("cur_day", 16'(want.day), 16'(got.day));
			check_field("cur_month", 16'(want.month), 16'(got.month));
			check_field("cur_year", want.year, got.year);
			check_field("is_before", 16'(want.earlier), 16'(got.earlier));
			check_field("is_after", 16'(want.later), 16'(got.later));
			check_field("is_equal", 16'(want.same), 16'(got.same));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [4:0]  in_day;
	logic [3:0]  in_month;
	logic [15:0] in_year;
	logic [15:0] day_count;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  cur_day;
	logic [3:0]  cur_month;
	logic [15:0] cur_year;
	logic        is_before;
	logic        is_after;
	logic        is_equal;

	date_scoreboard sb = new();
	int unsigned    idle_cycles = 0;

	gregorian_date_add_sub_compare dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.in_day    (in_day),
		.in_month  (in_month),
		.in_year   (in_year),
		.day_count (day_count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cur_day   (cur_day),
		.cur_month (cur_month),
		.cur_year  (cur_year),
		.is_before (is_before),
		.is_after  (is_after),
		.is_equal  (is_equal)
	);

	always #6 clk = ~clk;

	// Both channels are observed at the rising edge, where the inputs driven at
	// the previous falling edge are stable and the block's outputs still show
	// their values from before the edge. Every accepted input transaction is
	// handed to the scoreboard and every accepted result is checked against
	// the oldest outstanding prediction. A result never reaches the output in
	// the cycle its input is accepted, so the order of the two calls within one
	// edge does not matter. The same block keeps the watchdog.
	always @(posedge clk) begin
		date_txn_t t;
		date_res_t r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				t.op = gdate_pkg::op_t'(op);
				t.day = in_day;
				t.month = in_month;
				t.year = in_year;
				t.count = day_count;
				sb.accept_txn(t);
			end
			if (out_valid && !out_stall) begin
				r.day = cur_day;
				r.month = cur_month;
				r.year = cur_year;
				r.earlier = is_before;
				r.later = is_after;
				r.same = is_equal;
				sb.check_result(r);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$error("no transaction on either channel for %0d cycles", WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// The receiver switches between free flow, light and heavy random stalling
	// and solid holds, each for a random number of cycles, so that stalls land
	// on every phase of the block's work. Changes happen at the falling edge.
	initial begin
		rx_mode_t    mode;
		int unsigned len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			len = (mode == RX_HOLD) ? $urandom_range(1, 25) : $urandom_range(1, 60);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					RX_FREE: out_stall = 1'b0;
					RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
					default: out_stall = 1'b1;
				endcase
			end
		end
	end

	function automatic date_txn_t mk(gdate_pkg::op_t o, int unsigned d, int unsigned m,
			int unsigned y, int unsigned n);
		date_txn_t t;
		t.op = o;
		t.day = 5'(d);
		t.month = 4'(m);
		t.year = 16'(y);
		t.count = 16'(n);
		return t;
	endfunction

	// Mostly well-formed dates, with years spread over the ordinary range,
	// century years and the two ends of the wrap. A small share carries a day
	// of zero or past the end of the month, or a month outside one to twelve.
	function automatic void rand_date(output logic [4:0] d, output logic [3:0] m,
			output logic [15:0] y);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			y = 16'($urandom_range(1900, 2100));
		end else if (pick < 45) begin
			y = 16'($urandom_range(0, 655) * 100);
		end else if (pick < 60) begin
			y = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(65528, 65535)) :
				16'($urandom_range(0, 7));
		end else begin
			y = 16'($urandom_range(0, 65535));
		end
		m = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(1, 12));
		d = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, sb.month_days(m, y)));
	endfunction

	// Builds one random transaction. It runs after the previous transaction has
	// reached the scoreboard, so compares can be aimed at the date now held.
	function automatic date_txn_t gen_txn();
		date_txn_t   t;
		int unsigned pick;
		cmp_mode_t   cmode;
		t.day = 5'($urandom_range(0, 31));
		t.month = 4'($urandom_range(0, 15));
		t.year = 16'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			t.count = 16'($urandom_range(0, 40));
		end else if (pick < 75) begin
			t.count = 16'($urandom_range(0, 400));
		end else if (pick < 90) begin
			t.count = 16'($urandom_range(0, 3000));
		end else if (pick < 97) begin
			t.count = 16'($urandom_range(0, 65535));
		end else begin
			t.count = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		end
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			t.op = gdate_pkg::OP_LOAD;
			rand_date(t.day, t.month, t.year);
		end else if (pick < 48) begin
			t.op = gdate_pkg::OP_ADD;
		end else if (pick < 78) begin
			t.op = gdate_pkg::OP_SUB;
		end else begin
			t.op = gdate_pkg::OP_CMP;
			cmode = cmp_mode_t'($urandom_range(0, 4));
			t.day = sb.day[4:0];
			t.month = sb.month;
			t.year = sb.year;
			case (cmode)
				CMP_SAME: begin
				end
				CMP_YEAR_OFF: begin
					t.year = ($urandom_range(0, 1) != 0) ?
						sb.year + 16'($urandom_range(1, 3)) :
						sb.year - 16'($urandom_range(1, 3));
				end
				CMP_MONTH_OFF: begin
					t.month = ($urandom_range(0, 1) != 0) ? sb.month + 4'd1 :
						sb.month - 4'd1;
					t.day = 5'($urandom_range(0, 31));
				end
				CMP_DAY_OFF: begin
					t.day = ($urandom_range(0, 1) != 0) ? sb.day[4:0] + 5'd1 :
						sb.day[4:0] - 5'd1;
				end
				default: begin
					rand_date(t.day, t.month, t.year);
				end
			endcase
		end
		return t;
	endfunction

	// Presents one transaction from the current falling edge and holds it until
	// a rising edge accepts it. Callers step to the falling edge first.
	task automatic put_txn(input date_txn_t t);
		op = t.op;
		in_day = t.day;
		in_month = t.month;
		in_year = t.year;
		day_count = t.count;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops sending and waits until every predicted result has been checked.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_dates.size() != 0) @(posedge clk);
	endtask

	initial begin
		date_txn_t   directed_q[$];
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = gdate_pkg::OP_LOAD;
		in_day = '0;
		in_month = '0;
		in_year = '0;
		day_count = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. It starts from the reset date, crosses the year wrap
		// in both directions, walks over the leap day of a leap century, a
		// non-leap century and an ordinary leap year, and then works through
		// an oversized day, a zero day, months outside one to twelve, every
		// compare outcome and the largest day count both ways.
		directed_q.push_back(mk(gdate_pkg::OP_CMP, 1, 1, 0, 0));
		directed_q.push_back(mk(gdate_pkg::OP_SUB, 0, 0, 0, 1));
		directed_q.push_back(mk(gdate_pkg::OP_ADD, 31, 15, 65535, 1));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 28, 2, 1900, 0));
		directed_q.push_back(mk(gdate_pkg::OP_ADD, 0, 0, 0, 1));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 28, 2, 2000, 65535));
		directed_q.push_back(mk(gdate_pkg::OP_ADD, 0, 0, 0, 1));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 1, 3, 2024, 0));
		directed_q.push_back(mk(gdate_pkg::OP_SUB, 0, 0, 0, 1));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 31, 2, 2023, 0));
		directed_q.push_back(mk(gdate_pkg::OP_ADD, 0, 0, 0, 0));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 0, 3, 2023, 0));
		directed_q.push_back(mk(gdate_pkg::OP_SUB, 0, 0, 0, 0));
		directed_q.push_back(mk(gdate_pkg::OP_SUB, 0, 0, 0, 1));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 15, 0, 100, 0));
		directed_q.push_back(mk(gdate_pkg::OP_ADD, 0, 0, 0, 20));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 10, 0, 5, 0));
		directed_q.push_back(mk(gdate_pkg::OP_SUB, 0, 0, 0, 15));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 31, 13, 65535, 0));
		directed_q.push_back(mk(gdate_pkg::OP_ADD, 0, 0, 0, 1));
		directed_q.push_back(mk(gdate_pkg::OP_CMP, 1, 1, 1, 0));
		directed_q.push_back(mk(gdate_pkg::OP_LOAD, 15, 6, 2000, 0));
		directed_q.push_back(mk(gdate_pkg::OP_CMP, 15, 6, 1999, 0));
		directed_q.push_back(mk(gdate_pkg::OP_CMP, 15, 7, 2000, 0));
		directed_q.push_back(mk(gdate_pkg::OP_CMP, 14, 6, 2000, 0));
		directed_q.push_back(mk(gdate_pkg::OP_CMP, 15, 6, 2000, 0));
		directed_q.push_back(mk(gdate_pkg::OP_ADD, 0, 0, 0, 65535));
		directed_q.push_back(mk(gdate_pkg::OP_SUB, 0, 0, 0, 65535));
		foreach (directed_q[i]) begin
			@(negedge clk);
			if ($urandom_range(0, 2) == 0) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
			put_txn(directed_q[i]);
		end
		drain();

		// Random part in bursts. Halfway through, the sender holds off until
		// every outstanding result has been delivered, so the block is seen
		// going fully idle and starting again from an empty pipeline.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			repeat (burst) begin
				@(negedge clk);
				put_txn(gen_txn());
				sent++;
				if (sent == RANDOM_ITEMS / 2) drain();
			end
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) :
				$urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d loads, %0d adds, %0d subtracts and %0d compares.",
			sb.op_seen[gdate_pkg::OP_LOAD], sb.op_seen[gdate_pkg::OP_ADD],
			sb.op_seen[gdate_pkg::OP_SUB], sb.op_seen[gdate_pkg::OP_CMP]);
		$display("Before/after/equal %0d/%0d/%0d, largest day count %0d, year wraps %0d.",
			sb.flag_seen[0], sb.flag_seen[1], sb.flag_seen[2], sb.max_count,
			sb.year_wraps);
		if (sb.fails == 0 && sb.pending_dates.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/gdate_pkg.sv
hw/rtl/gdate_dp.sv
hw/rtl/gdate_ctrl.sv
hw/rtl/gregorian_date_add_sub_compare.sv
tb/sv/gregorian_date_add_sub_compare_tb.sv
